// ===== rtl/idq_pkg.sv =====
// Shared types and constants for the indexed double-ended queue.
// No dependencies; imported by the queue top level and by the bench.
package idq_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_READ_AT    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// ===== rtl/idq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/indexed_double_ended_queue_unit.sv =====
// Indexed double-ended queue: ring store in one RAM, front slot and count in flops.
// Depends on idq_pkg and idq_ram.
// Sequencer: latch the beat, execute, shift entries up for an insert (S_SH_RD and
//   S_SH_WR per moved entry), read the front, read the back, then load the result. One
//   item at a time: the shared RAM address and the shared slot adder are walked by the
//   sequencer; a new beat is taken only back in S_IDLE, and S_DONE waits out an output stall.
// Reset (rst, synchronous): queue empty, front slot 0, no result pending.
module indexed_double_ended_queue_unit
  import idq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic [SLOT_W-1:0]       position,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DATA_W-1:0] read_value,
  output logic signed [DATA_W-1:0] front_value,
  output logic signed [DATA_W-1:0] back_value,
  output logic [CNT_W-1:0]        element_total,
  output logic                    is_empty,
  output logic [ST_W-1:0]         status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_RD_FRONT,
    S_RD_BACK,
    S_DONE
  } state_t;

  state_t              state;

  // latched beat
  logic [OP_W-1:0]     op_reg;
  logic [DATA_W-1:0]   val_reg;
  logic [SLOT_W-1:0]   pos_reg;

  // queue state
  logic [SLOT_W-1:0]   front_slot;
  logic [CNT_W-1:0]    count;

  // shift cursor for insert (logical index being filled)
  logic [CNT_W-1:0]    k;

  // result under construction
  status_t             res_status;
  logic [DATA_W-1:0]   res_read;
  logic [DATA_W-1:0]   res_front;

  // shared slot adder and RAM hookup
  logic [SLOT_W-1:0]   ofs;
  logic [SLOT_W-1:0]   slot_addr;
  logic                wr_en;
  logic [DATA_W-1:0]   wr_data;
  logic [DATA_W-1:0]   rd_data;

  logic                full;
  logic                empty;
  logic                pos_oor;
  logic                shift_more;
  logic [CNT_W-1:0]    k_dec;
  logic [CNT_W-1:0]    cnt_dec;
  status_t             exec_status;
  logic                out_free;

  assign full       = (count == CNT_W'(CAPACITY));
  assign empty      = (count == '0);
  assign pos_oor    = ({1'b0, pos_reg} >= count);
  assign shift_more = (k > {1'b0, pos_reg});
  assign k_dec      = k - 1'b1;
  assign cnt_dec    = count - 1'b1;
  assign out_free   = !out_valid || !out_stall;

  // Every position maps to a ring slot through this one adder.
  assign slot_addr  = front_slot + ofs;

  // Only one beat in flight; the output register holds a finished result
  // while the next beat is taken.
  assign in_stall   = (state != S_IDLE);

  // Outcome of the latched operation against the current queue.
  always_comb begin
    exec_status = ST_OK;
    case (op_reg)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) exec_status = ST_FULL;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) exec_status = ST_EMPTY;
      end
      OP_INSERT_AT: begin
        // range check first, so insert on empty reports out of range
        if (pos_oor) exec_status = ST_RANGE;
        else if (full) exec_status = ST_FULL;
      end
      OP_READ_AT: begin
        if (empty) exec_status = ST_EMPTY;
        else if (pos_oor) exec_status = ST_RANGE;
      end
      default: exec_status = ST_OK;
    endcase
  end

  // Offset selection and RAM write control per sequencer step.
  always_comb begin
    ofs     = '0;
    wr_en   = 1'b0;
    wr_data = val_reg;
    case (state)
      S_EXEC: begin
        case (op_reg)
          OP_PUSH_FRONT: begin
            ofs   = '1;           // slot before the front
            wr_en = !full;
          end
          OP_PUSH_BACK: begin
            ofs   = count[SLOT_W-1:0];
            wr_en = !full;
          end
          OP_READ_AT: ofs = pos_reg;
          default:    ofs = '0;
        endcase
      end
      S_SH_RD: begin
        if (shift_more) begin
          ofs = k_dec[SLOT_W-1:0];  // fetch the entry that moves up
        end else begin
          ofs   = pos_reg;          // gap is open: drop the new value in
          wr_en = 1'b1;
        end
      end
      S_SH_WR: begin
        ofs     = k[SLOT_W-1:0];
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_RD_FRONT:         ofs = '0;
      S_RD_BACK, S_DONE:  ofs = cnt_dec[SLOT_W-1:0];
      default:            ofs = '0;
    endcase
  end

  idq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_addr),
    .wr_data (wr_data),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      front_slot <= '0;
      count      <= '0;
    end else begin
      // S_DONE owns out_valid on its own cycle: it reloads the register there
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_reg  <= operation;
            val_reg <= new_value;
            pos_reg <= position;
            state   <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_status <= exec_status;
          state      <= S_RD_FRONT;
          if (exec_status == ST_OK) begin
            case (op_reg)
              OP_PUSH_FRONT: begin
                front_slot <= slot_addr;
                count      <= count + 1'b1;
              end
              OP_POP_FRONT: begin
                front_slot <= front_slot + 1'b1;
                count      <= cnt_dec;
              end
              OP_PUSH_BACK: count <= count + 1'b1;
              OP_POP_BACK:  count <= cnt_dec;
              OP_INSERT_AT: begin
                k     <= count;
                state <= S_SH_RD;
              end
              default: ;
            endcase
          end
        end

        S_SH_RD: begin
          if (shift_more) begin
            state <= S_SH_WR;
          end else begin
            count <= count + 1'b1;
            state <= S_RD_FRONT;
          end
        end

        S_SH_WR: begin
          k     <= k_dec;
          state <= S_SH_RD;
        end

        S_RD_FRONT: begin
          // read-at data issued in S_EXEC lands now
          if (op_reg == OP_READ_AT && res_status == ST_OK) res_read <= rd_data;
          else res_read <= '0;
          state <= S_RD_BACK;
        end

        S_RD_BACK: begin
          res_front <= empty ? '0 : rd_data;
          state     <= S_DONE;
        end

        S_DONE: begin
          // back slot address is held here, so rd_data stays put while waiting
          if (out_free) begin
            out_valid     <= 1'b1;
            read_value    <= res_read;
            front_value   <= res_front;
            back_value    <= empty ? '0 : rd_data;
            element_total <= count;
            is_empty      <= empty;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_indexed_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for indexed_double_ended_queue_unit: directed and random deque traffic.
// Needs idq_pkg and the queue RTL; predicts each result beat with its own ring-store copy.
module tb_indexed_double_ended_queue_unit;
  import idq_pkg::*;

  // codes 6 and 7 are not decoded by the block; they must pass through as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    logic [SLOT_W-1:0]        pos;
  } deque_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] rd;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CNT_W-1:0]         total;
    logic                     is_empty;
    status_t                  st;
  } deque_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = '0;
  logic signed [DATA_W-1:0] new_value = '0;
  logic [SLOT_W-1:0]        position  = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         element_total;
  logic                     is_empty;
  logic [ST_W-1:0]          status;

  // beats waiting to be offered, and reports waiting to come back
  deque_op_t     op_backlog[$];
  deque_report_t pending_reports[$];

  // bench copy of the queue contents
  logic signed [DATA_W-1:0] model_store [CAPACITY];
  int model_front = 0;
  int model_count = 0;

  // element count as the stimulus generator expects it once the backlog is consumed
  int planned_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int fault_count = 0;
  int cycle_count = 0;

  indexed_double_ended_queue_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .new_value     (new_value),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .front_value   (front_value),
    .back_value    (back_value),
    .element_total (element_total),
    .is_empty      (is_empty),
    .status        (status)
  );

  always #1 clk = ~clk;

  // Applies one operation to the bench copy and returns the report the block should give.
  // Failed operations leave the store alone; insert checks range before fullness.
  function automatic deque_report_t apply_deque_op(deque_op_t it);
    deque_report_t r;
    logic full;
    int k;
    r.rd = '0;
    r.st = ST_OK;
    full = (model_count >= CAPACITY);
    case (it.op)
      OP_PUSH_FRONT: begin
        if (full) begin
          r.st = ST_FULL;
        end else begin
          model_front = (model_front + CAPACITY - 1) % CAPACITY;
          model_store[model_front] = it.val;
          model_count++;
        end
      end
      OP_POP_FRONT: begin
        if (model_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          model_front = (model_front + 1) % CAPACITY;
          model_count--;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          r.st = ST_FULL;
        end else begin
          model_store[(model_front + model_count) % CAPACITY] = it.val;
          model_count++;
        end
      end
      OP_POP_BACK: begin
        if (model_count == 0) r.st = ST_EMPTY;
        else model_count--;
      end
      OP_INSERT_AT: begin
        if (int'(it.pos) >= model_count) begin
          r.st = ST_RANGE;
        end else if (full) begin
          r.st = ST_FULL;
        end else begin
          // open a gap at pos by moving the tail one slot back
          for (k = model_count; k > int'(it.pos); k--)
            model_store[(model_front + k) % CAPACITY] =
              model_store[(model_front + k - 1) % CAPACITY];
          model_store[(model_front + int'(it.pos)) % CAPACITY] = it.val;
          model_count++;
        end
      end
      OP_READ_AT: begin
        if (model_count == 0) r.st = ST_EMPTY;
        else if (int'(it.pos) >= model_count) r.st = ST_RANGE;
        else r.rd = model_store[(model_front + int'(it.pos)) % CAPACITY];
      end
      default: ;
    endcase
    if (model_count > 0) begin
      r.front = model_store[model_front];
      r.back  = model_store[(model_front + model_count - 1) % CAPACITY];
    end else begin
      r.front = '0;
      r.back  = '0;
    end
    r.total    = model_count[CNT_W-1:0];
    r.is_empty = (model_count == 0);
    return r;
  endfunction

  // Driver: predicts on each accepted beat, holds a stalled beat steady,
  // otherwise offers the next backlog entry unless it chooses to idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_reports.insert(pending_reports.size(), apply_deque_op(op_backlog[0]));
        op_backlog.delete(0);
      end
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          operation <= op_backlog[0].op;
          new_value <= op_backlog[0].val;
          position  <= op_backlog[0].pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the generator can keep feeding beats.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go && hold_left == 0) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Monitor: every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    deque_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN)
            $display("unexpected result beat: rd=%0d front=%0d back=%0d n=%0d empty=%0b st=%0d",
                     read_value, front_value, back_value, element_total, is_empty, status);
        end else begin
          want = pending_reports[0];
          pending_reports.delete(0);
          if (read_value !== want.rd || front_value !== want.front ||
              back_value !== want.back || element_total !== want.total ||
              is_empty !== want.is_empty || status !== want.st) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN) begin
              $write("mismatch: exp rd=%0d front=%0d back=%0d n=%0d empty=%0b st=%0d",
                     want.rd, want.front, want.back, want.total, want.is_empty, want.st);
              $display(" | got rd=%0d front=%0d back=%0d n=%0d empty=%0b st=%0d",
                       read_value, front_value, back_value, element_total, is_empty, status);
            end
          end
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Queues a beat and tracks what the element count will be once it is applied.
  task automatic enqueue_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val,
                            logic [SLOT_W-1:0] pos);
    deque_op_t it;
    it.op  = op;
    it.val = val;
    it.pos = pos;
    op_backlog.insert(op_backlog.size(), it);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (planned_count < CAPACITY) planned_count++;
      OP_POP_FRONT, OP_POP_BACK:   if (planned_count > 0) planned_count--;
      OP_INSERT_AT: if (int'(pos) < planned_count && planned_count < CAPACITY) planned_count++;
      default: ;
    endcase
  endtask

  // Mostly random words, now and then the sign extremes and the all-zero/all-one patterns.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // One random beat; at or above the ceiling, pushes and inserts turn into pops so the queue stays short
  // and insert shifts stay cheap.
  task automatic queue_random_op(int ceiling);
    int roll;
    int span;
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] pos;
    roll = $urandom_range(99);
    span = (planned_count > CAPACITY - 1) ? CAPACITY - 1 : planned_count;
    // positions mostly land in or just past the held range
    pos = ($urandom_range(4) == 0) ? SLOT_W'($urandom_range(CAPACITY - 1))
                                   : SLOT_W'($urandom_range(span));
    if (roll < 5) begin
      op  = OP_W'($urandom_range(7));
      pos = SLOT_W'($urandom_range(CAPACITY - 1));
    end else if (roll < 23) op = OP_PUSH_FRONT;
    else if (roll < 41)     op = OP_PUSH_BACK;
    else if (roll < 53)     op = OP_POP_FRONT;
    else if (roll < 65)     op = OP_POP_BACK;
    else if (roll < 80)     op = OP_INSERT_AT;
    else                    op = OP_READ_AT;
    if (planned_count >= ceiling) begin
      if (op == OP_PUSH_FRONT) op = OP_POP_BACK;
      else if (op == OP_PUSH_BACK || op == OP_INSERT_AT) op = OP_POP_FRONT;
    end
    enqueue_op(op, pick_value(), pos);
  endtask

  // Waits until every queued beat is taken and every report has come back.
  task automatic wait_quiet();
    while (op_backlog.size() != 0 || in_valid || pending_reports.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int i;
    int roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase 1: slow-ish sender, heavily stalling receiver
    send_idle_pct  = 36;
    recv_stall_pct = 76;

    // empty-queue corner cases
    enqueue_op(OP_POP_FRONT, pick_value(), '0);
    enqueue_op(OP_POP_BACK, pick_value(), '0);
    enqueue_op(OP_READ_AT, '0, '0);
    enqueue_op(OP_INSERT_AT, 32'sd17, '0);  // insert on empty is out of range
    enqueue_op(OP_SPARE_6, '1, 8'd255);
    enqueue_op(OP_SPARE_7, VAL_MIN, '0);
    // value extremes at both ends
    enqueue_op(OP_PUSH_BACK, VAL_MAX, '0);
    enqueue_op(OP_PUSH_FRONT, VAL_MIN, 8'd255);
    enqueue_op(OP_PUSH_BACK, '0, '0);
    enqueue_op(OP_PUSH_BACK, '1, '0);
    enqueue_op(OP_READ_AT, '0, 8'd0);
    enqueue_op(OP_READ_AT, '0, 8'd3);
    enqueue_op(OP_READ_AT, '0, 8'd4);       // one past the end
    enqueue_op(OP_READ_AT, '0, 8'd255);
    // insert at the head acts as a front push
    enqueue_op(OP_INSERT_AT, 32'sd5, 8'd0);
    enqueue_op(OP_INSERT_AT, 32'sh5a5a_5a5a, 8'd2);
    enqueue_op(OP_INSERT_AT, -32'sd99, 8'd5);   // just before the last element
    enqueue_op(OP_INSERT_AT, 32'sd1, 8'd7);     // at count: out of range
    enqueue_op(OP_READ_AT, '0, 8'd6);
    enqueue_op(OP_POP_FRONT, '0, '0);
    enqueue_op(OP_POP_BACK, '0, '0);
    enqueue_op(OP_READ_AT, '0, 8'd0);
    enqueue_op(OP_INSERT_AT, pick_value(), 8'd255);
    for (i = 0; i < 100; i++) queue_random_op(24);
    wait_quiet();

    // phase 2: roles swapped; a long receiver hold-off fills the block up
    send_idle_pct  = 76;
    recv_stall_pct = 36;
    for (i = 0; i < 100; i++) queue_random_op(24);
    hold_go = 1'b1;
    while (hold_left == 0) @(negedge clk);
    hold_go = 1'b0;
    wait_quiet();

    // phase 3: no idling; fill to capacity so the ring wraps and the full cases show
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (planned_count < CAPACITY) begin
      roll = $urandom_range(19);
      if (roll < 2 && planned_count > 0)
        enqueue_op(OP_INSERT_AT, pick_value(), SLOT_W'($urandom_range(planned_count - 1)));
      else if (roll < 11)
        enqueue_op(OP_PUSH_FRONT, pick_value(), '0);
      else
        enqueue_op(OP_PUSH_BACK, pick_value(), '0);
    end
    enqueue_op(OP_PUSH_FRONT, pick_value(), '0);
    enqueue_op(OP_PUSH_BACK, pick_value(), '0);
    enqueue_op(OP_INSERT_AT, pick_value(), 8'd0);
    enqueue_op(OP_INSERT_AT, pick_value(), 8'd255);  // valid position, queue full
    enqueue_op(OP_READ_AT, '0, 8'd255);
    enqueue_op(OP_READ_AT, '0, 8'd0);
    enqueue_op(OP_READ_AT, '0, SLOT_W'($urandom_range(CAPACITY - 1)));
    enqueue_op(OP_SPARE_7, pick_value(), SLOT_W'($urandom_range(CAPACITY - 1)));
    for (i = 0; i < 70; i++) queue_random_op(200);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
